### rtl/core/spr_pkg.sv
// Shared types, field widths and parameter defaults for the slotted page record store.
package spr_pkg;

    // Field widths of the request and response channels
    localparam int REQ_TYPE_W   = 2;
    localparam int SLOT_INDEX_W = 8;
    localparam int ROW_LEN_W    = 13;
    localparam int BYTE_POS_W   = 12;
    localparam int DATA_W       = 8;
    localparam int STATUS_W     = 3;
    localparam int SLOT_ID_W    = 9;

    // Streaming byte position saturates at the top of its range
    localparam int PROGRESS_MAX = (1 << ROW_LEN_W) - 1;

    // Parameter defaults
    localparam int DEF_PAGE_SIZE    = 4096;
    localparam int DEF_MAX_ROW      = 4096;
    localparam int DEF_SLOT_BYTES   = 8;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int DEF_MAX_SLOTS    = 256;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_INSERT,
        REQ_UPDATE,
        REQ_DELETE,
        REQ_READ
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_TOO_LARGE,
        ST_PAGE_FULL,
        ST_RELOCATE,
        ST_DELETED,
        ST_BAD_INDEX
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_EMIT
    } fsm_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

### rtl/core/spr_req_if.sv
// Request channel: one record byte, delete or read request per transfer.
interface spr_req_if import spr_pkg::*; ();

    logic                    valid;
    logic                    ready;
    req_type_t               req_type;
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [ROW_LEN_W-1:0]    row_len;
    logic [BYTE_POS_W-1:0]   byte_pos;
    logic [DATA_W-1:0]       data_byte;
    logic                    last_byte;

    modport source (
        output valid, req_type, slot_index, row_len, byte_pos, data_byte, last_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, slot_index, row_len, byte_pos, data_byte, last_byte,
        output ready
    );

endinterface

### rtl/core/spr_rsp_if.sv
// Response channel: one result per request.
interface spr_rsp_if import spr_pkg::*; ();

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [SLOT_ID_W-1:0] new_slot_id;
    logic [DATA_W-1:0]    read_data;
    logic [ROW_LEN_W-1:0] row_length;
    logic                 row_valid;
    logic                 op_done;

    modport source (
        output valid, status, new_slot_id, read_data, row_length, row_valid, op_done,
        input  ready
    );

    modport sink (
        input  valid, status, new_slot_id, read_data, row_length, row_valid, op_done,
        output ready
    );

endinterface

### rtl/core/spr_ram.sv
// Synchronous RAM with one write port and one registered read port.
module spr_ram import spr_pkg::*; #(
    parameter int DEPTH = DEF_MAX_SLOTS,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data; hold it between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/slotted_page_record_store_top.sv
// Slotted page record store: control, page header registers and the two memories.
//
// Usage
//   req carries one item per transfer: an insert or update byte (streamed with
//   row_len repeated and last_byte on the final byte), a delete or a byte read.
//   rsp returns exactly one result per request, in order. Slots are addressed
//   newest first: slot_index 0 is the most recent insert.
// Sequence
//   A request is accepted in IDLE, the slot directory entry is read at that
//   edge, the request executes in the next cycle (page and directory write, or
//   page read), and the result enters the output register from EMIT once
//   that register is free; only then is the next request accepted.
// Reset
//   Header state returns to an empty page: no slots, free top at PAGE_SIZE,
//   directory end at HEADER_BYTES, no stream in progress. Memory contents are
//   not cleared and are read only where written before.
// Stall
//   While a result waits in the output register, the next request is still
//   accepted and executed; it then holds until the output register frees.
module slotted_page_record_store_top import spr_pkg::*; #(
    parameter int PAGE_SIZE    = DEF_PAGE_SIZE,
    parameter int MAX_ROW      = DEF_MAX_ROW,
    parameter int SLOT_BYTES   = DEF_SLOT_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS
) (
    input  logic     clk,
    input  logic     rst_n,
    spr_req_if.sink  req,
    spr_rsp_if.source rsp
);

    localparam int PAGE_AW = $clog2(PAGE_SIZE);
    localparam int PTR_W   = $clog2(PAGE_SIZE + 1);
    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int DIR_W   = $clog2(HEADER_BYTES + SLOT_BYTES * MAX_SLOTS + 1);
    localparam int CMP_W   = max_int(max_int(max_int(ROW_LEN_W, PTR_W),
                                             max_int(DIR_W, $clog2(MAX_ROW + 1))),
                                     max_int(CNT_W, SLOT_INDEX_W)) + 1;
    localparam int SLOT_W  = PAGE_AW + ROW_LEN_W + 1;

    // Control and header state
    fsm_t                   state_reg, state_next;
    logic [CNT_W-1:0]       slot_count_reg, slot_count_next;
    logic [PTR_W-1:0]       free_top_reg, free_top_next;
    logic [DIR_W-1:0]       dir_end_reg, dir_end_next;
    logic [ROW_LEN_W-1:0]   progress_reg, progress_next;
    logic                   failed_reg, failed_next;
    logic                   out_valid_reg, out_valid_next;

    // Latched request
    req_type_t              type_reg;
    logic                   good_reg;
    logic [SLOT_AW-1:0]     phys_reg;
    logic [ROW_LEN_W-1:0]   rlen_reg;
    logic [BYTE_POS_W-1:0]  bpos_reg;
    logic [DATA_W-1:0]      data_reg;
    logic                   last_reg;

    // Result held between execute and emit
    status_t                res_status_reg, res_status_next;
    logic [SLOT_ID_W-1:0]   res_id_reg, res_id_next;
    logic [ROW_LEN_W-1:0]   res_len_reg, res_len_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   res_done_reg, res_done_next;
    logic                   rd_hit_reg, rd_hit_next;

    // Output register
    status_t                out_status_reg;
    logic [SLOT_ID_W-1:0]   out_id_reg;
    logic [DATA_W-1:0]      out_data_reg;
    logic [ROW_LEN_W-1:0]   out_len_reg;
    logic                   out_row_valid_reg;
    logic                   out_done_reg;

    // Memory ports
    logic                   slot_we, slot_re;
    logic [SLOT_AW-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]      slot_wdata, slot_rdata;
    logic                   page_we, page_re;
    logic [PAGE_AW-1:0]     page_waddr, page_raddr;
    logic [DATA_W-1:0]      page_rdata;

    // Execute-stage decode
    logic                   accept, exec, out_load;
    logic [PAGE_AW-1:0]     s_off;
    logic [ROW_LEN_W-1:0]   s_len;
    logic                   s_vld;
    logic [CMP_W-1:0]       rlen_c, ft_c, de_c, cnt_c, prog_c;
    logic                   ok_wr;
    logic                   in_good;
    logic [SLOT_AW-1:0]     in_phys;

    spr_ram #(.DEPTH(MAX_SLOTS), .WIDTH(SLOT_W), .AW(SLOT_AW)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    spr_ram #(.DEPTH(PAGE_SIZE), .WIDTH(DATA_W), .AW(PAGE_AW)) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (data_reg),
        .re    (page_re),
        .raddr (page_raddr),
        .rdata (page_rdata)
    );

    // Map the slot position from newest first to its directory entry
    assign in_good = CMP_W'(req.slot_index) < CMP_W'(slot_count_reg);
    assign in_phys = SLOT_AW'(CMP_W'(slot_count_reg) - CMP_W'(1) - CMP_W'(req.slot_index));

    assign accept     = req.valid && req.ready;
    assign exec       = (state_reg == FSM_EXEC);
    assign out_load   = (state_reg == FSM_EMIT) && (!out_valid_reg || rsp.ready);
    assign slot_re    = accept;
    assign slot_raddr = in_phys;

    // Split the directory entry
    assign s_off = slot_rdata[PAGE_AW-1:0];
    assign s_len = slot_rdata[PAGE_AW +: ROW_LEN_W];
    assign s_vld = slot_rdata[SLOT_W-1];

    assign rlen_c = CMP_W'(rlen_reg);
    assign ft_c   = CMP_W'(free_top_reg);
    assign de_c   = CMP_W'(dir_end_reg);
    assign cnt_c  = CMP_W'(slot_count_reg);
    assign prog_c = CMP_W'(progress_reg);

    // Execute the request: checks, memory reads and writes, and header updates
    always_comb
    begin
        res_status_next = ST_OK;
        res_id_next     = '0;
        res_len_next    = '0;
        res_valid_next  = 1'b0;
        res_done_next   = 1'b1;
        rd_hit_next     = 1'b0;
        slot_we         = 1'b0;
        slot_waddr      = phys_reg;
        slot_wdata      = slot_rdata;
        page_we         = 1'b0;
        page_waddr      = PAGE_AW'(s_off + PAGE_AW'(progress_reg));
        page_re         = 1'b0;
        page_raddr      = PAGE_AW'(s_off + PAGE_AW'(bpos_reg));
        slot_count_next = slot_count_reg;
        free_top_next   = free_top_reg;
        dir_end_next    = dir_end_reg;
        progress_next   = progress_reg;
        failed_next     = failed_reg;
        ok_wr           = 1'b0;

        unique case (type_reg) inside
            REQ_INSERT, REQ_UPDATE:
            begin
                res_done_next = last_reg;
                if (rlen_c == '0)
                begin
                    res_status_next = ST_EMPTY;
                end
                else if (rlen_c > CMP_W'(MAX_ROW))
                begin
                    res_status_next = ST_TOO_LARGE;
                end
                else if (type_reg == REQ_INSERT)
                begin
                    if (rlen_c > ft_c || (ft_c - rlen_c) < de_c ||
                        cnt_c >= CMP_W'(MAX_SLOTS))
                    begin
                        res_status_next = ST_PAGE_FULL;
                    end
                end
                else if (!good_reg)
                begin
                    res_status_next = ST_BAD_INDEX;
                end
                else if (rlen_reg > s_len)
                begin
                    res_status_next = ST_RELOCATE;
                    slot_we         = exec;
                    slot_wdata      = {1'b0, s_len, s_off};
                end

                ok_wr = (res_status_next == ST_OK) && !failed_reg;

                // Write the streamed byte
                if (ok_wr && prog_c < rlen_c)
                begin
                    page_we = exec;
                    if (type_reg == REQ_INSERT)
                    begin
                        page_waddr = PAGE_AW'(ft_c - rlen_c + prog_c);
                    end
                end

                if (type_reg == REQ_UPDATE && good_reg)
                begin
                    res_len_next   = s_len;
                    res_valid_next = (res_status_next == ST_RELOCATE) ? 1'b0 : s_vld;
                end

                // Commit on the last byte, or advance the stream
                if (last_reg)
                begin
                    if (ok_wr)
                    begin
                        if (type_reg == REQ_INSERT)
                        begin
                            slot_we         = exec;
                            slot_waddr      = SLOT_AW'(slot_count_reg);
                            slot_wdata      = {1'b1, rlen_reg, PAGE_AW'(ft_c - rlen_c)};
                            slot_count_next = CNT_W'(cnt_c + CMP_W'(1));
                            free_top_next   = PTR_W'(ft_c - rlen_c);
                            dir_end_next    = DIR_W'(de_c + CMP_W'(SLOT_BYTES));
                            res_id_next     = SLOT_ID_W'(cnt_c + CMP_W'(1));
                        end
                        else if (rlen_reg < s_len)
                        begin
                            slot_we      = exec;
                            slot_wdata   = {s_vld, rlen_reg, s_off};
                            res_len_next = rlen_reg;
                        end
                    end
                    progress_next = '0;
                    failed_next   = 1'b0;
                end
                else
                begin
                    if (progress_reg != ROW_LEN_W'(PROGRESS_MAX))
                    begin
                        progress_next = progress_reg + ROW_LEN_W'(1);
                    end
                    if (res_status_next != ST_OK)
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
            REQ_DELETE:
            begin
                if (!good_reg)
                begin
                    res_status_next = ST_BAD_INDEX;
                end
                else
                begin
                    if (s_vld)
                    begin
                        slot_we    = exec;
                        slot_wdata = {1'b0, s_len, s_off};
                    end
                    else
                    begin
                        res_status_next = ST_DELETED;
                    end
                    res_len_next = s_len;
                end
            end
            REQ_READ:
            begin
                if (!good_reg)
                begin
                    res_status_next = ST_BAD_INDEX;
                end
                else
                begin
                    res_len_next   = s_len;
                    res_valid_next = s_vld;
                    if (ROW_LEN_W'(bpos_reg) < s_len)
                    begin
                        rd_hit_next = 1'b1;
                        page_re     = exec;
                    end
                end
            end
            default:
            begin
                res_status_next = ST_OK;
            end
        endcase
    end

    // Sequence the request and the output register
    always_comb
    begin
        state_next     = state_reg;
        req.ready      = 1'b0;
        out_valid_next = out_valid_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                state_next = FSM_EMIT;
            end
            FSM_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Hold control and header state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            slot_count_reg <= '0;
            free_top_reg   <= PTR_W'(PAGE_SIZE);
            dir_end_reg    <= DIR_W'(HEADER_BYTES);
            progress_reg   <= '0;
            failed_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (exec)
            begin
                slot_count_reg <= slot_count_next;
                free_top_reg   <= free_top_next;
                dir_end_reg    <= dir_end_next;
                progress_reg   <= progress_next;
                failed_reg     <= failed_next;
            end
        end
    end

    // Latch the request, the result and the output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req.req_type;
            good_reg <= in_good;
            phys_reg <= in_phys;
            rlen_reg <= req.row_len;
            bpos_reg <= req.byte_pos;
            data_reg <= req.data_byte;
            last_reg <= req.last_byte;
        end
        if (exec)
        begin
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_len_reg    <= res_len_next;
            res_valid_reg  <= res_valid_next;
            res_done_reg   <= res_done_next;
            rd_hit_reg     <= rd_hit_next;
        end
        if (out_load)
        begin
            out_status_reg    <= res_status_reg;
            out_id_reg        <= res_id_reg;
            out_data_reg      <= rd_hit_reg ? page_rdata : '0;
            out_len_reg       <= res_len_reg;
            out_row_valid_reg <= res_valid_reg;
            out_done_reg      <= res_done_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.new_slot_id = out_id_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.row_length  = out_len_reg;
    assign rsp.row_valid   = out_row_valid_reg;
    assign rsp.op_done     = out_done_reg;

endmodule

### rtl/core/spr_chk.sv
// Port-level checks for the slotted page record store, bound to the top level.
module spr_chk import spr_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input status_t              rsp_status,
    input logic [SLOT_ID_W-1:0] rsp_new_slot_id,
    input logic [DATA_W-1:0]    rsp_read_data,
    input logic [ROW_LEN_W-1:0] rsp_row_length,
    input logic                 rsp_row_valid,
    input logic                 rsp_op_done
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_new_slot_id) && $stable(rsp_read_data) && $stable(rsp_row_length))
        else $error("stalled response changed");

    // Drop ready after each request: one request in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while one is in flight");

    // A new slot id comes only with a completed, clean insert
    a_slot_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_new_slot_id != '0 |-> rsp_op_done && rsp_status == ST_OK)
        else $error("slot id on a failed or unfinished request");

    // Bad index reports no slot and no data
    a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_BAD_INDEX |->
        rsp_row_length == '0 && !rsp_row_valid && rsp_read_data == '0 &&
        rsp_new_slot_id == '0)
        else $error("bad index result carries slot data");

endmodule

bind slotted_page_record_store_top spr_chk u_spr_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_new_slot_id (rsp.new_slot_id),
    .rsp_read_data   (rsp.read_data),
    .rsp_row_length  (rsp.row_length),
    .rsp_row_valid   (rsp.row_valid),
    .rsp_op_done     (rsp.op_done)
);
